@@ design/ssrg_pkg.sv @@
// ----------------------------------------------------------------------------
// ssrg_pkg
// Shared constants, register codes and digit helpers for the step ramp generator.
// ----------------------------------------------------------------------------
package ssrg_pkg;

  localparam int PosW      = 32;
  localparam int PerW      = 16;
  localparam int TolW      = 8;
  localparam int DigitW    = 4;
  localparam int CalcW     = 36;
  localparam int NumDigits = CalcW / DigitW;
  localparam int CntW      = 4;

  localparam int InDataW   = 32;
  localparam int OutFieldW = PosW + 3;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;
  localparam int OutPadW   = OutDataW - OutFieldW;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] CfgEnable     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTolerance  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFastPeriod = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSlowPeriod = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRampSteps  = 3'd4;

  localparam logic            ReqTick        = 1'b0;
  localparam logic            ReqTarget      = 1'b1;

  localparam logic            RstEnable      = 1'b1;
  localparam logic [TolW-1:0] RstTolerance   = 8'd5;
  localparam logic [PerW-1:0] RstFastPeriod  = 16'd1000;
  localparam logic [PerW-1:0] RstSlowPeriod  = 16'd2000;
  localparam logic [PerW-1:0] RstRampSteps   = 16'd200;

  // a + ~b + cin on one digit; carry out in the top bit
  function automatic logic [DigitW:0] dig_sub(input logic [DigitW-1:0] a,
                                              input logic [DigitW-1:0] b,
                                              input logic              cin);
    logic [DigitW:0] s;
    s = {1'b0, a} + {1'b0, ~b} + {{DigitW{1'b0}}, cin};
    return s;
  endfunction

  // LSB-first less-than: a higher digit overrides the lower result
  function automatic logic dig_lt(input logic [DigitW-1:0] a,
                                  input logic [DigitW-1:0] b,
                                  input logic              lt_prev);
    logic r;
    r = (a < b) | ((a == b) & lt_prev);
    return r;
  endfunction

endpackage

@@ design/stepper_step_ramp_generator.sv @@
// ----------------------------------------------------------------------------
// stepper_step_ramp_generator
// Stepper step generator with a trapezoidal period ramp, digit-serial datapath.
//
// Channel   Dir  Content (LSB first)                         Handshake
// s_axis    in   tuser: req_type; tdata: target_value         tvalid/tready
// m_axis    out  tdata: step_pulse, direction, position,      tvalid/tready
//                moving, zero pad
// cfg       in   cfg_idx_i selects register, cfg_data_i       cfg_we_i
//
// Every beat runs a 4-bit digit pass over 36-bit distances; a step that
// falls inside the ramp also runs the restoring divider for the ramp period.
// Reset is asynchronous, active low, and loads the register defaults.
// The next input beat is taken while a result still waits on m_axis; the
// block holds before its result stage until the output register frees.
// ----------------------------------------------------------------------------
module stepper_step_ramp_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ssrg_pkg::InDataW-1:0]   s_axis_tdata,   // [31:0] target_value
  input  logic                           s_axis_tuser,   // [0] req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] step_pulse, [1] direction, [33:2] position, [34] moving, [39:35] zero
  output logic [ssrg_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [ssrg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ssrg_pkg::CfgDataW-1:0]  cfg_data_i
);
  import ssrg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_CALC, ST_DECIDE, ST_MUL, ST_DIV, ST_PERIOD, ST_DONE
  } state_e;

  typedef struct packed {
    logic tp_gt_tol;
    logic pt_gt_tol;
    logic tp_gt_tol1;
    logic pt_gt_tol1;
    logic tp_lt_n;
    logic pt_lt_n;
    logic ps_lt_n;
    logic sp_lt_n;
    logic ps_lt_tp;
    logic ps_lt_pt;
    logic sp_lt_tp;
    logic sp_lt_pt;
  } cmp_t;

  state_e              state_q;
  logic [CntW-1:0]     cnt_q;

  logic                en_q;
  logic [TolW-1:0]     tol_q;
  logic [PerW-1:0]     fast_q;
  logic [PerW-1:0]     slow_q;
  logic [PerW-1:0]     ramp_q;

  logic [PosW-1:0]     pos_q;
  logic [PosW-1:0]     target_q;
  logic [PosW-1:0]     start_q;
  logic [PerW-1:0]     elapsed_q;
  logic [PerW-1:0]     period_q;
  logic                is_tick_q;

  logic [CalcW-1:0]    t_sr_q, p_sr_q, s_sr_q;
  logic [PerW-1:0]     tol_sr_q, tol1_sr_q, n_sr_q;
  logic [CalcW-1:0]    tp_q, pt_q, ps_q, sp_q;
  logic [3:0]          carry_q;
  cmp_t                cmp_q, cmp_d;

  logic [PerW-1:0]     div_r_q, div_q_q;

  logic                res_pulse_q, res_dir_q, res_moving_q;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic [DigitW:0]     s_tp, s_pt, s_ps, s_sp;
  logic [DigitW-1:0]   tol_dig, tol1_dig, n_dig;

  logic                rem_neg, fs_neg;
  logic                gt_tol, gt_tol1, rem_lt_n, fs_lt_n, fs_lt_rem, r_lt_n;
  logic [PerW-1:0]     r_lo, m_w, d_w;
  logic                step_ok;
  logic [PerW-1:0]     elapsed_d;
  logic [PosW-1:0]     pos_d;
  logic [PerW:0]       rem17, sub17;
  logic                div_ge;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    tol_dig  = tol_sr_q[DigitW-1:0];
    tol1_dig = tol1_sr_q[DigitW-1:0];
    n_dig    = n_sr_q[DigitW-1:0];
    s_tp = dig_sub(t_sr_q[DigitW-1:0], p_sr_q[DigitW-1:0], carry_q[0]);
    s_pt = dig_sub(p_sr_q[DigitW-1:0], t_sr_q[DigitW-1:0], carry_q[1]);
    s_ps = dig_sub(p_sr_q[DigitW-1:0], s_sr_q[DigitW-1:0], carry_q[2]);
    s_sp = dig_sub(s_sr_q[DigitW-1:0], p_sr_q[DigitW-1:0], carry_q[3]);

    cmp_d.tp_gt_tol  = dig_lt(tol_dig, s_tp[DigitW-1:0], cmp_q.tp_gt_tol);
    cmp_d.pt_gt_tol  = dig_lt(tol_dig, s_pt[DigitW-1:0], cmp_q.pt_gt_tol);
    cmp_d.tp_gt_tol1 = dig_lt(tol1_dig, s_tp[DigitW-1:0], cmp_q.tp_gt_tol1);
    cmp_d.pt_gt_tol1 = dig_lt(tol1_dig, s_pt[DigitW-1:0], cmp_q.pt_gt_tol1);
    cmp_d.tp_lt_n    = dig_lt(s_tp[DigitW-1:0], n_dig, cmp_q.tp_lt_n);
    cmp_d.pt_lt_n    = dig_lt(s_pt[DigitW-1:0], n_dig, cmp_q.pt_lt_n);
    cmp_d.ps_lt_n    = dig_lt(s_ps[DigitW-1:0], n_dig, cmp_q.ps_lt_n);
    cmp_d.sp_lt_n    = dig_lt(s_sp[DigitW-1:0], n_dig, cmp_q.sp_lt_n);
    cmp_d.ps_lt_tp   = dig_lt(s_ps[DigitW-1:0], s_tp[DigitW-1:0], cmp_q.ps_lt_tp);
    cmp_d.ps_lt_pt   = dig_lt(s_ps[DigitW-1:0], s_pt[DigitW-1:0], cmp_q.ps_lt_pt);
    cmp_d.sp_lt_tp   = dig_lt(s_sp[DigitW-1:0], s_tp[DigitW-1:0], cmp_q.sp_lt_tp);
    cmp_d.sp_lt_pt   = dig_lt(s_sp[DigitW-1:0], s_pt[DigitW-1:0], cmp_q.sp_lt_pt);
  end

  always_comb begin
    rem_neg  = tp_q[CalcW-1];
    fs_neg   = ps_q[CalcW-1];
    gt_tol   = rem_neg ? cmp_q.pt_gt_tol  : cmp_q.tp_gt_tol;
    gt_tol1  = rem_neg ? cmp_q.pt_gt_tol1 : cmp_q.tp_gt_tol1;
    rem_lt_n = rem_neg ? cmp_q.pt_lt_n    : cmp_q.tp_lt_n;
    fs_lt_n  = fs_neg  ? cmp_q.sp_lt_n    : cmp_q.ps_lt_n;
    unique case ({fs_neg, rem_neg})
      2'b00:   fs_lt_rem = cmp_q.ps_lt_tp;
      2'b01:   fs_lt_rem = cmp_q.ps_lt_pt;
      2'b10:   fs_lt_rem = cmp_q.sp_lt_tp;
      default: fs_lt_rem = cmp_q.sp_lt_pt;
    endcase
    r_lt_n = fs_lt_rem ? fs_lt_n : rem_lt_n;
    if (fs_lt_rem) begin
      r_lo = fs_neg ? sp_q[PerW-1:0] : ps_q[PerW-1:0];
    end else begin
      r_lo = rem_neg ? pt_q[PerW-1:0] : tp_q[PerW-1:0];
    end
    m_w = ramp_q - r_lo;
    d_w = (slow_q < fast_q) ? '0 : slow_q - fast_q;

    step_ok   = is_tick_q & en_q & gt_tol & (elapsed_q >= period_q);
    elapsed_d = (elapsed_q == {PerW{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
    pos_d     = rem_neg ? pos_q - 1'b1 : pos_q + 1'b1;

    rem17  = {div_r_q, div_q_q[PerW-1]};
    sub17  = rem17 - {1'b0, ramp_q};
    div_ge = (rem17 >= {1'b0, ramp_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      en_q         <= RstEnable;
      tol_q        <= RstTolerance;
      fast_q       <= RstFastPeriod;
      slow_q       <= RstSlowPeriod;
      ramp_q       <= RstRampSteps;
      pos_q        <= '0;
      target_q     <= '0;
      start_q      <= '0;
      elapsed_q    <= '0;
      period_q     <= RstFastPeriod;
      is_tick_q    <= 1'b0;
      res_pulse_q  <= 1'b0;
      res_dir_q    <= 1'b0;
      res_moving_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgEnable:     en_q   <= cfg_data_i[0];
          CfgTolerance:  tol_q  <= cfg_data_i[TolW-1:0];
          CfgFastPeriod: fast_q <= cfg_data_i[PerW-1:0];
          CfgSlowPeriod: slow_q <= cfg_data_i[PerW-1:0];
          CfgRampSteps:  ramp_q <= cfg_data_i[PerW-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser == ReqTarget) begin
              target_q  <= s_axis_tdata[PosW-1:0];
              start_q   <= pos_q;
              is_tick_q <= 1'b0;
            end else begin
              elapsed_q <= elapsed_d;
              is_tick_q <= 1'b1;
            end
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          t_sr_q    <= {{(CalcW-PosW){target_q[PosW-1]}}, target_q};
          p_sr_q    <= {{(CalcW-PosW){pos_q[PosW-1]}}, pos_q};
          s_sr_q    <= {{(CalcW-PosW){start_q[PosW-1]}}, start_q};
          tol_sr_q  <= {{(PerW-TolW){1'b0}}, tol_q};
          tol1_sr_q <= {{(PerW-TolW){1'b0}}, tol_q} + 1'b1;
          n_sr_q    <= ramp_q;
          carry_q   <= '1;
          cmp_q     <= '0;
          cnt_q     <= '0;
          state_q   <= ST_CALC;
        end
        ST_CALC: begin
          t_sr_q    <= {{DigitW{1'b0}}, t_sr_q[CalcW-1:DigitW]};
          p_sr_q    <= {{DigitW{1'b0}}, p_sr_q[CalcW-1:DigitW]};
          s_sr_q    <= {{DigitW{1'b0}}, s_sr_q[CalcW-1:DigitW]};
          tol_sr_q  <= {{DigitW{1'b0}}, tol_sr_q[PerW-1:DigitW]};
          tol1_sr_q <= {{DigitW{1'b0}}, tol1_sr_q[PerW-1:DigitW]};
          n_sr_q    <= {{DigitW{1'b0}}, n_sr_q[PerW-1:DigitW]};
          tp_q      <= {s_tp[DigitW-1:0], tp_q[CalcW-1:DigitW]};
          pt_q      <= {s_pt[DigitW-1:0], pt_q[CalcW-1:DigitW]};
          ps_q      <= {s_ps[DigitW-1:0], ps_q[CalcW-1:DigitW]};
          sp_q      <= {s_sp[DigitW-1:0], sp_q[CalcW-1:DigitW]};
          carry_q   <= {s_sp[DigitW], s_ps[DigitW], s_pt[DigitW], s_tp[DigitW]};
          cmp_q     <= cmp_d;
          cnt_q     <= cnt_q + 1'b1;
          if (cnt_q == CntW'(NumDigits - 1)) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (is_tick_q && en_q && !gt_tol) begin
            period_q <= fast_q;
          end
          if (step_ok) begin
            elapsed_q    <= '0;
            pos_q        <= pos_d;
            res_pulse_q  <= 1'b1;
            res_dir_q    <= ~rem_neg;
            res_moving_q <= gt_tol1;
            if (r_lt_n) begin
              state_q <= ST_MUL;
            end else begin
              period_q <= fast_q;
              state_q  <= ST_DONE;
            end
          end else begin
            res_pulse_q  <= 1'b0;
            res_dir_q    <= 1'b0;
            res_moving_q <= gt_tol;
            state_q      <= ST_DONE;
          end
        end
        ST_MUL: begin
          {div_r_q, div_q_q} <= {{PerW{1'b0}}, d_w} * {{PerW{1'b0}}, m_w};
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          div_r_q <= div_ge ? sub17[PerW-1:0] : rem17[PerW-1:0];
          div_q_q <= {div_q_q[PerW-2:0], div_ge};
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == CntW'(PerW - 1)) begin
            state_q <= ST_PERIOD;
          end
        end
        ST_PERIOD: begin
          period_q <= fast_q + div_q_q;
          state_q  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_data_q  <= {{OutPadW{1'b0}}, res_moving_q, pos_q, res_dir_q, res_pulse_q};
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ test/tb_stepper_step_ramp_generator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stepper_step_ramp_generator
// Self-checking bench for the stepper ramp generator. A scoreboard class keeps
// its own copy of the position, target, move start, tick counter, period and
// registers, predicts one result beat per input beat and compares each output
// beat field by field. Directed beats cover zero period and ramp, slow below
// fast, extreme targets, tolerance edges and the disabled tick; a run of beats
// with no idling on either side follows; then random phases with random
// register settings, short moves, stalls and a long output hold.
// ----------------------------------------------------------------------------
module tb_stepper_step_ramp_generator;
  import ssrg_pkg::*;

  typedef struct packed {
    logic            pulse;
    logic            dir;
    logic [PosW-1:0] pos;
    logic            moving;
  } step_beat_t;

  class ramp_scoreboard;
    logic            en;
    logic [TolW-1:0] tol;
    logic [PerW-1:0] fast_per, slow_per, ramp_len;
    logic [PosW-1:0] pos, tgt, start;
    logic [PerW-1:0] elapsed, period;
    step_beat_t      expected_q[$];
    int              errors;

    function new();
      en = RstEnable;
      tol = RstTolerance;
      fast_per = RstFastPeriod;
      slow_per = RstSlowPeriod;
      ramp_len = RstRampSteps;
      pos = '0;
      tgt = '0;
      start = '0;
      elapsed = '0;
      period = RstFastPeriod;
      errors = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      case (idx)
        CfgEnable:     en = d[0];
        CfgTolerance:  tol = d[TolW-1:0];
        CfgFastPeriod: fast_per = d;
        CfgSlowPeriod: slow_per = d;
        CfgRampSteps:  ramp_len = d;
        default: ;
      endcase
    endfunction

    function longint abs_gap(logic [PosW-1:0] a, logic [PosW-1:0] b);
      longint d;
      d = longint'($signed(a)) - longint'($signed(b));
      return (d < 0) ? -d : d;
    endfunction

    function logic [PerW-1:0] ramp_period(longint r);
      longint f, s, n;
      f = fast_per;
      s = (slow_per < fast_per) ? fast_per : slow_per;
      n = ramp_len;
      if (r >= n) return fast_per;
      return PerW'(f + ((s - f) * (n - r)) / n);
    endfunction

    function void note_input(logic req, logic [InDataW-1:0] val);
      step_beat_t b;
      longint     diff, remaining, from_start, r;
      b = '0;
      if (req == ReqTarget) begin
        tgt = val;
        start = pos;
      end else begin
        if (elapsed != {PerW{1'b1}}) elapsed++;
        if (en) begin
          diff = longint'($signed(tgt)) - longint'($signed(pos));
          remaining = (diff < 0) ? -diff : diff;
          if (remaining <= tol) begin
            period = fast_per;
          end else if (elapsed >= period) begin
            from_start = abs_gap(pos, start);
            r = (from_start < remaining) ? from_start : remaining;
            elapsed = '0;
            period = ramp_period(r);
            b.pulse = 1'b1;
            if (diff > 0) begin
              b.dir = 1'b1;
              pos = pos + 1;
            end else begin
              pos = pos - 1;
            end
          end
        end
      end
      b.pos = pos;
      b.moving = abs_gap(tgt, pos) > tol;
      expected_q.push_back(b);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [OutDataW-1:0] d);
      step_beat_t e;
      if (expected_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      if (d[0] !== e.pulse)
        report($sformatf("step_pulse got %b want %b", d[0], e.pulse));
      if (d[1] !== e.dir)
        report($sformatf("direction got %b want %b", d[1], e.dir));
      if (d[PosW+1:2] !== e.pos)
        report($sformatf("position got %h want %h", d[PosW+1:2], e.pos));
      if (d[PosW+2] !== e.moving)
        report($sformatf("moving got %b want %b", d[PosW+2], e.moving));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;   // [31:0] target_value
  logic                 s_axis_tuser = 1'b0; // [0] req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [0] step_pulse, [1] direction, [33:2] position, [34] moving, [39:35] zero
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  ramp_scoreboard sb;
  bit idle_on = 1'b1;
  int hold_requests = 0;

  stepper_step_ramp_generator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #100000000;
    $display("FAIL");
    $finish;
  end

  // output side: random stalls plus a long hold on request
  initial begin
    int held;
    int served;
    held = 0;
    served = 0;
    forever begin
      @(posedge clk_i);
      if (held == 0 && served != hold_requests) begin
        held = 400;
        served++;
      end
      if (held != 0) begin
        m_axis_tready <= 1'b0;
        held--;
      end else if (idle_on && $urandom_range(99) < 18) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  task automatic drive_item(input logic req, input logic [InDataW-1:0] val);
    if (idle_on) begin
      while ($urandom_range(99) < 18) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= val;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(req, val);
  endtask

  task automatic ticks(input int n);
    for (int i = 0; i < n; i++) drive_item(ReqTick, $urandom);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic en, input logic [TolW-1:0] tol,
                            input logic [PerW-1:0] fast_v, input logic [PerW-1:0] slow_v,
                            input logic [PerW-1:0] ramp_v);
    logic [CfgIdxW-1:0]  idx [5];
    logic [CfgDataW-1:0] val [5];
    idx = '{CfgEnable, CfgTolerance, CfgFastPeriod, CfgSlowPeriod, CfgRampSteps};
    val = '{CfgDataW'(en), CfgDataW'(tol), fast_v, slow_v, ramp_v};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random_phase(input int n_items, input int ph);
    int              span;
    int              off;
    int              tgt_pct;
    logic            en;
    logic [TolW-1:0] tol;
    logic [PerW-1:0] fast_v, slow_v, ramp_v;
    logic [PosW-1:0] v;
    en = ($urandom_range(9) != 0);
    case ($urandom_range(3))
      0: tol = '0;
      1: tol = {TolW{1'b1}};
      default: tol = TolW'($urandom_range(8));
    endcase
    fast_v = ($urandom_range(4) == 0) ? PerW'($urandom_range(40)) : PerW'($urandom_range(3));
    if ($urandom_range(4) == 0 && fast_v != 0) slow_v = PerW'($urandom_range(fast_v - 1));
    else slow_v = fast_v + PerW'($urandom_range(16));
    case ($urandom_range(9))
      0: ramp_v = '0;
      1: ramp_v = {PerW{1'b1}};
      2: ramp_v = PerW'(1);
      default: ramp_v = PerW'($urandom_range(12, 2));
    endcase
    set_config(en, tol, fast_v, slow_v, ramp_v);
    tgt_pct = $urandom_range(12, 3);
    for (int i = 0; i < n_items; i++) begin
      if (ph == 2 && i == n_items / 2) wait_drained();
      if (ph == 5 && i == n_items / 3) hold_requests++;
      if ($urandom_range(99) < tgt_pct) begin
        case ($urandom_range(9))
          0: v = $urandom;
          1: v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          default: begin
            span = int'(sb.tol) + 25;
            off = int'($urandom_range(2 * span)) - span;
            v = sb.pos + PosW'(off);
          end
        endcase
        drive_item(ReqTarget, v);
      end else begin
        drive_item(ReqTick, $urandom);
      end
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero period and zero ramp length
    set_config(1'b1, 8'd0, 16'd0, 16'd3, 16'd0);
    drive_item(ReqTarget, 32'd3);
    ticks(4);
    drive_item(ReqTarget, 32'hFFFF_FFFE);
    ticks(3);
    wait_drained();

    // slow below fast, longest ramp, extreme targets, tolerance edge
    set_config(1'b1, 8'd255, 16'd2, 16'd1, 16'hFFFF);
    drive_item(ReqTarget, 32'h7FFF_FFFF);
    ticks(2);
    drive_item(ReqTarget, 32'h8000_0000);
    ticks(2);
    drive_item(ReqTarget, sb.pos + 32'd255);
    ticks(1);
    drive_item(ReqTarget, sb.pos + 32'd256);
    ticks(2);
    wait_drained();

    // disabled ticks
    set_config(1'b0, 8'd5, 16'd1, 16'd4, 16'd2);
    ticks(2);
    drive_item(ReqTarget, 32'd20);
    ticks(1);
    wait_drained();

    // back-to-back beats with no idling on either side
    idle_on = 1'b0;
    set_config(1'b1, 8'd0, 16'd1, 16'd6, 16'd4);
    drive_item(ReqTarget, sb.pos + 32'd30);
    ticks(80);
    wait_drained();
    idle_on = 1'b1;

    for (int ph = 0; ph < 10; ph++) run_random_phase(100, ph);

    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
